[hdl/tdoa_pkg.sv]
// tdoa_pkg: shared constants and the arctangent table for the direction-of-arrival block.
// No dependencies.
`default_nettype none
package tdoa_pkg;
	localparam int TIME_W            = 24;
	localparam int TIME_BITS_DEF     = 24;
	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int ANGLE_W           = 16;
	localparam int SLOPE_W           = 32;
	localparam int ZW                = 26;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 16'd46080;
	localparam logic [ANGLE_W-1:0] ANGLE_HALF = 16'd23040;
	localparam logic signed [ZW-1:0] DEG90    = 26'sd5898240;
	localparam logic [SLOPE_W-1:0] SLOPE_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [SLOPE_W-1:0] SLOPE_NEG_MAX = 32'h8000_0000;

	// atan(2^-i) in degrees, 1/65536 units
	function automatic logic signed [ZW-1:0] atan_q16(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = 26'sd2949120;
			1: v = 26'sd1740967;
			2: v = 26'sd919879;
			3: v = 26'sd466945;
			4: v = 26'sd234379;
			5: v = 26'sd117304;
			6: v = 26'sd58666;
			7: v = 26'sd29335;
			8: v = 26'sd14668;
			9: v = 26'sd7334;
			10: v = 26'sd3667;
			11: v = 26'sd1833;
			12: v = 26'sd917;
			13: v = 26'sd458;
			14: v = 26'sd229;
			15: v = 26'sd115;
			16: v = 26'sd57;
			17: v = 26'sd29;
			18: v = 26'sd14;
			19: v = 26'sd7;
			20: v = 26'sd4;
			21: v = 26'sd2;
			22: v = 26'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

[hdl/tdoa_in_if.sv]
// tdoa_in_if: input channel carrying one set of six arrival times.
// Depends on tdoa_pkg.
`default_nettype none
interface tdoa_in_if;
	logic                      valid;
	logic                      ready;
	logic [tdoa_pkg::TIME_W-1:0] time_y_pos;
	logic [tdoa_pkg::TIME_W-1:0] time_y_neg;
	logic [tdoa_pkg::TIME_W-1:0] time_x_pos;
	logic [tdoa_pkg::TIME_W-1:0] time_x_neg;
	logic [tdoa_pkg::TIME_W-1:0] time_z_pos;
	logic [tdoa_pkg::TIME_W-1:0] time_z_neg;
	modport source (output valid, time_y_pos, time_y_neg, time_x_pos, time_x_neg,
		time_z_pos, time_z_neg, input ready);
	modport sink (input valid, time_y_pos, time_y_neg, time_x_pos, time_x_neg,
		time_z_pos, time_z_neg, output ready);
endinterface

// tdoa_out_if: result channel, angle and slope.
interface tdoa_out_if;
	logic                               valid;
	logic                               ready;
	logic [tdoa_pkg::ANGLE_W-1:0]       angle;
	logic signed [tdoa_pkg::SLOPE_W-1:0] slope;
	logic                               slope_saturated;
	modport source (output valid, angle, slope, slope_saturated, input ready);
	modport sink (input valid, angle, slope, slope_saturated, output ready);
endinterface
`default_nettype wire

[hdl/tdoa_direction_angle.sv]
// tdoa_direction_angle: pipelined direction of arrival from six microphone arrival times.
// Depends on tdoa_pkg and the channel interfaces in tdoa_in_if.sv.
//
// Usage:
//   times  : one item = six arrival tick counts (y, x, z axis pairs). Only the low
//            TIME_BITS bits of each count are used.
//   result : one item per input item = polar angle from the x axis (1/256 degree),
//            slope r/dx in signed Q16.16 and a saturation flag.
// Pipeline: difference, square and sum stages, then RB square-root stages, where
//   RB = TIME_BITS + 17 (bits of the root, one per square-root stage), then DS stages
//   with DS = max(RB, CORDIC_STEPS) (the CORDIC and the divider run side by side,
//   the divider taking one quotient bit per stage), then an output register.
// Throughput: one item per cycle unless stalled; every stage is a register with a valid bit.
// Stall: when result is valid and not taken, the whole pipeline holds; times.ready
//   drops in the same cycle, so nothing is lost or repeated. Empty bubbles are
//   not squeezed out.
// Reset: arst_n clears all valid bits at once; the block takes items from the first
//   clock after release.
`default_nettype none
module tdoa_direction_angle #(
	parameter int TIME_BITS    = tdoa_pkg::TIME_BITS_DEF,
	parameter int CORDIC_STEPS = tdoa_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	tdoa_in_if.sink       times,
	tdoa_out_if.source    result
);
	import tdoa_pkg::*;

	localparam int TB = TIME_BITS;
	localparam int RB = TB + 17;             // root bits
	localparam int NW = 2 * RB;              // square-root remainder width
	localparam int SW = 2 * TB + 1;          // sum of squares
	localparam int CW = TB + 28;             // CORDIC datapath, signed
	localparam int DS = (RB > CORDIC_STEPS) ? RB : CORDIC_STEPS;
	localparam int QW = (RB > 33) ? RB : 33;

	logic en;
	assign en = !result.valid || result.ready;
	assign times.ready = en;

	// stage 1: pair differences as magnitudes, and the sign of the x difference
	logic [TB-1:0] yp, yn, xp, xn, zp, zn;
	assign yp = TB'(times.time_y_pos);
	assign yn = TB'(times.time_y_neg);
	assign xp = TB'(times.time_x_pos);
	assign xn = TB'(times.time_x_neg);
	assign zp = TB'(times.time_z_pos);
	assign zn = TB'(times.time_z_neg);

	logic          v_s1;
	logic [TB-1:0] my_s1, mx_s1, mz_s1;
	logic          sx_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			my_s1 <= (yn < yp) ? yp - yn : yn - yp;
			mx_s1 <= (xn < xp) ? xp - xn : xn - xp;
			mz_s1 <= (zn < zp) ? zp - zn : zn - zp;
			sx_s1 <= xn < xp;
		end
	end

	// stage 2: squares
	logic            v_s2;
	logic [2*TB-1:0] qy_s2, qz_s2;
	logic [TB-1:0]   mx_s2;
	logic            sx_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			qy_s2 <= my_s1 * my_s1;
			qz_s2 <= mz_s1 * mz_s1;
			mx_s2 <= mx_s1;
			sx_s2 <= sx_s1;
		end
	end

	// stage 3: sum of squares
	logic          v_s3;
	logic [SW-1:0] sum_s3;
	logic [TB-1:0] mx_s3;
	logic          sx_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= SW'(qy_s2) + SW'(qz_s2);
			mx_s3  <= mx_s2;
			sx_s3  <= sx_s2;
		end
	end

	// square root of sum * 2^32, one root bit per stage, MSB first
	logic          sq_v_s   [RB];
	logic [NW-1:0] sq_rem_s [RB];
	logic [RB-1:0] sq_root_s[RB];
	logic [TB-1:0] sq_mx_s  [RB];
	logic          sq_sx_s  [RB];

	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		localparam int B = RB - 1 - k;
		logic [NW-1:0] rem_in, trial;
		logic [RB-1:0] root_in;
		logic [TB-1:0] mx_in;
		logic          sx_in;
		if (k == 0) begin : g_first
			assign rem_in  = NW'({sum_s3, 32'd0});
			assign root_in = '0;
			assign mx_in   = mx_s3;
			assign sx_in   = sx_s3;
		end else begin : g_next
			assign rem_in  = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign mx_in   = sq_mx_s[k-1];
			assign sx_in   = sq_sx_s[k-1];
		end
		// (root + 2^B)^2 - root^2
		assign trial = (NW'(root_in) << (B + 1)) | (NW'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					sq_rem_s[k]  <= rem_in - trial;
					sq_root_s[k] <= root_in | (RB'(1) << B);
				end else begin
					sq_rem_s[k]  <= rem_in;
					sq_root_s[k] <= root_in;
				end
				sq_mx_s[k] <= mx_in;
				sq_sx_s[k] <= sx_in;
			end
		end
	end

	// CORDIC vectoring and restoring divider, side by side
	logic                 c_v_s   [DS];
	logic signed [CW-1:0] c_x_s   [DS];
	logic signed [CW-1:0] c_y_s   [DS];
	logic signed [ZW-1:0] c_z_s   [DS];
	logic [RB-1:0]        d_rem_s [DS];
	logic [RB-1:0]        d_q_s   [DS];
	logic [RB-1:0]        c_rq_s  [DS];
	logic [TB-1:0]        c_mx_s  [DS];
	logic                 c_sx_s  [DS];

	logic [RB-1:0] rq;
	logic [TB-1:0] rq_mx;
	logic          rq_sx;
	assign rq    = sq_root_s[RB-1];
	assign rq_mx = sq_mx_s[RB-1];
	assign rq_sx = sq_sx_s[RB-1];

	for (genvar k = 0; k < DS; k++) begin : g_cd
		logic signed [CW-1:0] x_in, y_in;
		logic signed [ZW-1:0] z_in;
		logic [RB-1:0]        rem_in, q_in, rq_in;
		logic [TB-1:0]        mx_in;
		logic                 sx_in;
		if (k == 0) begin : g_first
			// negative dx: pre-rotate by -90 degrees
			assign x_in   = rq_sx ? CW'({rq, 8'd0}) : CW'({rq_mx, 24'd0});
			assign y_in   = rq_sx ? CW'({rq_mx, 24'd0}) : CW'({rq, 8'd0});
			assign z_in   = rq_sx ? DEG90 : '0;
			assign rem_in = rq;
			assign q_in   = '0;
			assign rq_in  = rq;
			assign mx_in  = rq_mx;
			assign sx_in  = rq_sx;
		end else begin : g_next
			assign x_in   = c_x_s[k-1];
			assign y_in   = c_y_s[k-1];
			assign z_in   = c_z_s[k-1];
			assign rem_in = d_rem_s[k-1];
			assign q_in   = d_q_s[k-1];
			assign rq_in  = c_rq_s[k-1];
			assign mx_in  = c_mx_s[k-1];
			assign sx_in  = c_sx_s[k-1];
		end

		if (k < CORDIC_STEPS) begin : g_rot
			always_ff @(posedge clk) begin
				if (en) begin
					if (y_in >= 0) begin
						c_x_s[k] <= x_in + (y_in >>> k);
						c_y_s[k] <= y_in - (x_in >>> k);
						c_z_s[k] <= z_in + atan_q16(k);
					end else begin
						c_x_s[k] <= x_in - (y_in >>> k);
						c_y_s[k] <= y_in + (x_in >>> k);
						c_z_s[k] <= z_in - atan_q16(k);
					end
				end
			end
		end else begin : g_rot_pass
			always_ff @(posedge clk) begin
				if (en) begin
					c_x_s[k] <= x_in;
					c_y_s[k] <= y_in;
					c_z_s[k] <= z_in;
				end
			end
		end

		if (k < RB) begin : g_div
			localparam int B = RB - 1 - k;
			always_ff @(posedge clk) begin
				if (en) begin
					if ((rem_in >> B) >= RB'(mx_in)) begin
						d_rem_s[k] <= rem_in - (RB'(mx_in) << B);
						d_q_s[k]   <= q_in | (RB'(1) << B);
					end else begin
						d_rem_s[k] <= rem_in;
						d_q_s[k]   <= q_in;
					end
				end
			end
		end else begin : g_div_pass
			always_ff @(posedge clk) begin
				if (en) begin
					d_rem_s[k] <= rem_in;
					d_q_s[k]   <= q_in;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c_rq_s[k] <= rq_in;
				c_mx_s[k] <= mx_in;
				c_sx_s[k] <= sx_in;
			end
		end
	end

	// final: special cases, rounding and saturation
	logic signed [ZW-1:0] zf, zr;
	logic [RB-1:0]        rqf;
	logic [TB-1:0]        mxf;
	logic                 sxf;
	logic [QW-1:0]        qf;
	logic [ANGLE_W-1:0]   angle_d;
	logic [SLOPE_W-1:0]   slope_d;
	logic                 sat_d;
	assign zf  = c_z_s[DS-1];
	assign rqf = c_rq_s[DS-1];
	assign mxf = c_mx_s[DS-1];
	assign sxf = c_sx_s[DS-1];
	assign qf  = QW'(d_q_s[DS-1]);
	assign zr  = (zf + ZW'(128)) >>> 8;

	always_comb begin
		if (rqf == '0) begin
			angle_d = (mxf != '0 && sxf) ? ANGLE_MAX : '0;
		end else if (mxf == '0) begin
			angle_d = ANGLE_HALF;
		end else if (zf <= 0) begin
			angle_d = '0;
		end else if (zr > ZW'(ANGLE_MAX)) begin
			angle_d = ANGLE_MAX;
		end else begin
			angle_d = ANGLE_W'(zr);
		end

		if (mxf == '0) begin
			slope_d = SLOPE_POS_MAX;
			sat_d   = 1'b1;
		end else if (!sxf) begin
			sat_d   = qf > QW'(SLOPE_POS_MAX);
			slope_d = sat_d ? SLOPE_POS_MAX : SLOPE_W'(qf);
		end else begin
			sat_d   = qf > QW'(SLOPE_NEG_MAX);
			slope_d = sat_d ? SLOPE_NEG_MAX : SLOPE_W'(-qf);
		end
	end

	logic               out_v_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [SLOPE_W-1:0] slope_q;
	logic               sat_q;
	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= angle_d;
			slope_q <= slope_d;
			sat_q   <= sat_d;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
			for (int k = 0; k < RB; k++) sq_v_s[k] <= 1'b0;
			for (int k = 0; k < DS; k++) c_v_s[k] <= 1'b0;
		end else if (en) begin
			v_s1      <= times.valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			sq_v_s[0] <= v_s3;
			for (int k = 1; k < RB; k++) sq_v_s[k] <= sq_v_s[k-1];
			c_v_s[0]  <= sq_v_s[RB-1];
			for (int k = 1; k < DS; k++) c_v_s[k] <= c_v_s[k-1];
			out_v_q   <= c_v_s[DS-1];
		end
	end

	assign result.valid           = out_v_q;
	assign result.angle           = angle_q;
	assign result.slope           = signed'(slope_q);
	assign result.slope_saturated = sat_q;

	// root is floor: remainder never exceeds twice the root
	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_s[RB-1] |-> sq_rem_s[RB-1] <= NW'({sq_root_s[RB-1], 1'b0}))
		else $error("square-root remainder out of range");

	// divider remainder below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		c_v_s[DS-1] && mxf != '0 |-> d_rem_s[DS-1] < RB'(mxf))
		else $error("divider remainder out of range");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> angle_q <= ANGLE_MAX)
		else $error("angle beyond 180 degrees");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && sat_q |-> slope_q == SLOPE_POS_MAX || slope_q == SLOPE_NEG_MAX)
		else $error("saturated slope not at a limit");
endmodule
`default_nettype wire

[bench/tb_tdoa_direction_angle.sv]
// tb_tdoa_direction_angle: self-checking bench for the direction-of-arrival block.
// Depends on tdoa_pkg, tdoa_in_if.sv and tdoa_direction_angle.sv.
`timescale 1ns / 100ps
`default_nettype none
module tb_tdoa_direction_angle;
	import tdoa_pkg::*;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic [SLOPE_W-1:0] slope;
		logic               sat;
	} doa_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   failed = 1'b0;
	bit   quiet_phase = 1'b0;   // no idling on either side while set
	doa_t expected_doa[$];

	tdoa_in_if  times();
	tdoa_out_if result();

	tdoa_direction_angle u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.times (times.sink),
		.result(result.source)
	);

	always #1 clk = ~clk;

	// Exact floor square root of a value of up to 100 bits, bit by bit.
	function automatic logic [63:0] floor_root(input logic [127:0] n);
		logic [63:0]  root;
		logic [63:0]  c;
		logic [127:0] sq;
		root = '0;
		for (int b = 49; b >= 0; b--) begin
			c = root | (64'd1 << b);
			sq = c * c;
			if (sq <= n)
				root = c;
		end
		return root;
	endfunction

	// Expected angle, slope and flag for one set of arrival times.
	function automatic doa_t predict_doa(input logic [23:0] yp, yn, xp, xn, zp, zn);
		logic [63:0]  my, mx, mz, rq, q;
		logic [127:0] sumsq;
		logic         sx;
		longint       x, y, z, xs, ys, a;
		doa_t         r;
		my = (yn >= yp) ? yn - yp : yp - yn;
		sx = xn < xp;
		mx = sx ? xp - xn : xn - xp;
		mz = (zn >= zp) ? zn - zp : zp - zn;
		sumsq = ((128'(my) * my) + (128'(mz) * mz)) << 32;
		rq = floor_root(sumsq);
		r.sat = 1'b0;
		if (rq == 0)
			r.angle = (mx != 0 && sx) ? ANGLE_MAX : '0;
		else if (mx == 0)
			r.angle = ANGLE_HALF;
		else begin
			z = 0;
			if (sx) begin
				x = longint'(rq << 8);
				y = longint'(mx << 24);
				z = 5898240;
			end else begin
				x = longint'(mx << 24);
				y = longint'(rq << 8);
			end
			for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys; y -= xs; z += longint'(atan_q16(i));
				end else begin
					x -= ys; y += xs; z -= longint'(atan_q16(i));
				end
			end
			if (z <= 0)
				r.angle = '0;
			else begin
				a = (z + 128) >>> 8;
				r.angle = (a > 46080) ? ANGLE_MAX : a[15:0];
			end
		end
		if (mx == 0) begin
			r.slope = SLOPE_POS_MAX;
			r.sat = 1'b1;
		end else begin
			q = rq / mx;
			if (!sx) begin
				if (q > 64'h7FFF_FFFF) begin q = 64'h7FFF_FFFF; r.sat = 1'b1; end
				r.slope = q[31:0];
			end else begin
				if (q > 64'h8000_0000) begin q = 64'h8000_0000; r.sat = 1'b1; end
				r.slope = 32'(0 - q);
			end
		end
		return r;
	endfunction

	function automatic bit gap_now();
		return !quiet_phase && ($urandom_range(99) < 20);
	endfunction

	// Sends one item, with a random idle gap first; valid is held until taken
	// and left high, so back-to-back items follow without an idle gap.
	task automatic send_times(input logic [23:0] yp, yn, xp, xn, zp, zn);
		while (gap_now()) begin
			times.valid <= 1'b0;
			@(posedge clk);
		end
		times.valid <= 1'b1;
		times.time_y_pos <= yp;
		times.time_y_neg <= yn;
		times.time_x_pos <= xp;
		times.time_x_neg <= xn;
		times.time_z_pos <= zp;
		times.time_z_neg <= zn;
		expected_doa.push_back(predict_doa(yp, yn, xp, xn, zp, zn));
		do @(posedge clk); while (!times.ready);
	endtask

	// Sink side: random back-pressure.
	always @(posedge clk)
		result.ready <= !gap_now();

	// Each accepted result against the oldest expectation.
	always @(posedge clk) begin
		doa_t e;
		if (arst_n && result.valid && result.ready) begin
			if (expected_doa.size() == 0) begin
				$display("%0t: result with none expected: angle %0d slope %h sat %0d",
					$time, result.angle, result.slope, result.slope_saturated);
				failed = 1'b1;
			end else begin
				e = expected_doa.pop_front();
				if (result.angle !== e.angle) begin
					$display("%0t: angle expected %0d actual %0d", $time, e.angle,
						result.angle);
					failed = 1'b1;
				end
				if (result.slope !== e.slope) begin
					$display("%0t: slope expected %h actual %h", $time, e.slope,
						result.slope);
					failed = 1'b1;
				end
				if (result.slope_saturated !== e.sat) begin
					$display("%0t: slope_saturated expected %0d actual %0d", $time,
						e.sat, result.slope_saturated);
					failed = 1'b1;
				end
			end
		end
	end

	// Extremes and the special cases of the geometry.
	task automatic test_directed();
		logic [23:0] m;
		m = 24'hFF_FFFF;
		send_times(0, 0, 0, 0, 0, 0);          // all differences zero
		send_times(m, m, m, m, m, m);
		send_times(5, 5, 0, 100, 9, 9);        // r zero, dx positive
		send_times(5, 5, 100, 0, 9, 9);        // r zero, dx negative
		send_times(0, 77, 3, 3, 0, 0);         // dx zero, r nonzero
		send_times(0, 0, 8, 8, m, 0);
		send_times(0, m, 0, 1, 0, m);          // positive slope overflow
		send_times(0, m, 1, 0, 0, m);          // negative slope overflow
		send_times(0, 1, 1, 0, 0, 0);          // slope of exactly -1
		send_times(0, 32768, 1, 0, 0, 0);      // magnitude exactly 2^31, dx < 0
		send_times(0, 32768, 0, 1, 0, 0);      // 2^31 with dx > 0 saturates
		send_times(0, m, 0, m, 0, m);
		send_times(m, 0, m, 0, m, 0);
		send_times(0, 1, 0, m, 0, 0);          // tiny angle
		send_times(0, m, 0, 1, m, 0);
		send_times(100, 0, 0, 100, 0, 0);      // 45 degrees
		send_times(100, 0, 100, 0, 0, 0);      // 135 degrees
		send_times(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555);
	endtask

	// Random sets: each time is either full range or a small offset from a common base.
	task automatic test_random(input int count);
		logic [23:0] t[6];
		logic [23:0] base;
		for (int n = 0; n < count; n++) begin
			quiet_phase = (n >= count / 2) && (n < count / 2 + 150);
			base = 24'($urandom);
			for (int k = 0; k < 6; k++)
				case ($urandom_range(3))
					0: t[k] = 24'($urandom);
					1: t[k] = 24'(base + $urandom_range(4095));
					2: t[k] = 24'(base + $urandom_range(15));
					default: t[k] = base;
				endcase
			send_times(t[0], t[1], t[2], t[3], t[4], t[5]);
		end
		quiet_phase = 1'b0;
	endtask

	initial begin
		times.valid = 1'b0;
		times.time_y_pos = '0;
		times.time_y_neg = '0;
		times.time_x_pos = '0;
		times.time_x_neg = '0;
		times.time_z_pos = '0;
		times.time_z_neg = '0;
		result.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1000);
		times.valid <= 1'b0;
		while (expected_doa.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (failed)
			$display("tdoa_direction_angle verification failed");
		else
			$display("tdoa_direction_angle verification clean");
		$finish;
	end

	// Watchdog: far above any clean run, even under heavy back-pressure.
	initial begin
		#200000;
		$display("tdoa_direction_angle verification failed");
		$finish;
	end
endmodule
`default_nettype wire
